/* rtl/sorted_priority_queue_unit_macros.svh */
// ----------------------------------------------------------------------------
// Sorted priority queue unit - assertion macros
// Concurrent assertion helpers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define SPQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted priority queue assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define SPQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted priority queue assertion failed");
`else
`define SPQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SPQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/spq_pkg.sv */
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Field types, operation and status codes, entry layout and sequencer states.
// ----------------------------------------------------------------------------
package spq_pkg;

    typedef logic [1:0]  t_op;
    typedef logic [1:0]  t_status;
    typedef logic [15:0] t_id;
    typedef logic [31:0] t_key;
    typedef logic [6:0]  t_occ;

    localparam t_op OP_PUSH   = 2'd0;
    localparam t_op OP_SORTED = 2'd1;
    localparam t_op OP_POP    = 2'd2;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_EMPTY = 2'd1;
    localparam t_status ST_FULL  = 2'd2;

    typedef struct packed {
        t_id  id;
        t_key runtime;
        t_key coverage;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        t_status status;
        t_id     popped_id;
        t_key    popped_runtime;
        t_key    popped_coverage;
        t_occ    occupancy;
    } t_result;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_PLACE,
        S_POP_DATA,
        S_DONE
    } t_state;

endpackage

/* rtl/spq_in_if.sv */
// ----------------------------------------------------------------------------
// Sorted priority queue request channel
// Valid/ready channel carrying one operation word.
// ----------------------------------------------------------------------------
interface spq_in_if;
    logic            valid;
    logic            ready;
    spq_pkg::t_op    operation;
    logic            order_by;
    spq_pkg::t_id    item_id;
    spq_pkg::t_key   item_runtime;
    spq_pkg::t_key   item_coverage;

    modport source (
        output valid, operation, order_by, item_id, item_runtime, item_coverage,
        input  ready
    );
    modport sink (
        input  valid, operation, order_by, item_id, item_runtime, item_coverage,
        output ready
    );
endinterface

/* rtl/spq_out_if.sv */
// ----------------------------------------------------------------------------
// Sorted priority queue response channel
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
interface spq_out_if;
    logic               valid;
    logic               ready;
    spq_pkg::t_status   status;
    spq_pkg::t_id       popped_id;
    spq_pkg::t_key      popped_runtime;
    spq_pkg::t_key      popped_coverage;
    spq_pkg::t_occ      occupancy;

    modport source (
        output valid, status, popped_id, popped_runtime, popped_coverage, occupancy,
        input  ready
    );
    modport sink (
        input  valid, status, popped_id, popped_runtime, popped_coverage, occupancy,
        output ready
    );
endinterface

/* rtl/spq_ram.sv */
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module spq_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/spq_seq.sv */
// ----------------------------------------------------------------------------
// Sorted priority queue sequencer
// Walks the circular entry store through a shared
// address unit and a shared key comparator.
// ----------------------------------------------------------------------------
module spq_seq #(
    parameter int CAPACITY = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    spq_in_if.sink                           i_req,
    input  logic                             i_out_free,
    output logic                             o_res_valid,
    output spq_pkg::t_result                 o_res,
    output logic [$clog2(CAPACITY+1)-1:0]    o_count
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [AW:0]   CAP_W = (AW + 1)'(CAPACITY);
    localparam logic [AW-1:0] LAST  = AW'(CAPACITY - 1);
    localparam logic [CW-1:0] FULL  = CW'(CAPACITY);

    spq_pkg::t_state  r_state, n_state;
    logic [AW-1:0]    r_head, n_head;
    logic [CW-1:0]    r_count, n_count;
    logic [AW-1:0]    r_pos, n_pos;
    logic [AW-1:0]    r_idx, n_idx;
    spq_pkg::t_op     r_op;
    logic             r_by;
    spq_pkg::t_entry  r_item;
    spq_pkg::t_status r_status, n_status;
    spq_pkg::t_entry  r_popped, n_popped;

    logic             accept;
    logic             is_full;
    logic             is_empty;
    logic [AW-1:0]    lg_addr;
    logic [AW:0]      addr_sum;
    logic [AW-1:0]    phys_addr;
    logic             ram_we;
    spq_pkg::t_entry  ram_wdata;
    spq_pkg::t_entry  ram_rdata;
    logic [spq_pkg::ENTRY_W-1:0] ram_rdata_raw;
    spq_pkg::t_key    new_key;
    spq_pkg::t_key    stored_key;
    logic             key_lower;
    logic             scan_last;
    logic [CW+6:0]    occ_ext;

    assign accept   = i_req.valid && i_req.ready;
    assign is_full  = (r_count == FULL);
    assign is_empty = (r_count == '0);

    // Shared address unit: logical slot relative to the front, wrapped once.
    always_comb begin
        unique case (r_state)
            spq_pkg::S_SCAN_RD:  lg_addr = r_pos;
            spq_pkg::S_SHIFT_RD: lg_addr = r_idx;
            spq_pkg::S_SHIFT_WR: lg_addr = r_idx + AW'(1);
            spq_pkg::S_PLACE:    lg_addr = r_pos;
            default:             lg_addr = '0;
        endcase
    end

    assign addr_sum  = {1'b0, r_head} + {1'b0, lg_addr};
    assign phys_addr = (addr_sum >= CAP_W) ? AW'(addr_sum - CAP_W) : addr_sum[AW-1:0];

    // Shared key comparator.
    assign ram_rdata  = spq_pkg::t_entry'(ram_rdata_raw);
    assign new_key    = r_by ? r_item.coverage : r_item.runtime;
    assign stored_key = r_by ? ram_rdata.coverage : ram_rdata.runtime;
    assign key_lower  = (stored_key < new_key);
    assign scan_last  = ((CW'(r_pos) + CW'(1)) == r_count);

    spq_ram #(
        .WIDTH (spq_pkg::ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (phys_addr),
        .i_wdata (ram_wdata),
        .i_raddr (phys_addr),
        .o_rdata (ram_rdata_raw)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            spq_pkg::S_IDLE: begin
                if (accept) begin
                    case (i_req.operation)
                        spq_pkg::OP_PUSH: begin
                            n_state = is_full ? spq_pkg::S_DONE : spq_pkg::S_PLACE;
                        end
                        spq_pkg::OP_SORTED: begin
                            if (is_full) begin
                                n_state = spq_pkg::S_DONE;
                            end else if (is_empty) begin
                                n_state = spq_pkg::S_PLACE;
                            end else begin
                                n_state = spq_pkg::S_SCAN_RD;
                            end
                        end
                        spq_pkg::OP_POP: begin
                            n_state = is_empty ? spq_pkg::S_DONE : spq_pkg::S_POP_DATA;
                        end
                        default: n_state = spq_pkg::S_DONE;
                    endcase
                end
            end
            spq_pkg::S_SCAN_RD:  n_state = spq_pkg::S_SCAN_CMP;
            spq_pkg::S_SCAN_CMP: begin
                if (key_lower) begin
                    n_state = spq_pkg::S_SHIFT_RD;
                end else if (scan_last) begin
                    n_state = spq_pkg::S_PLACE;
                end else begin
                    n_state = spq_pkg::S_SCAN_RD;
                end
            end
            spq_pkg::S_SHIFT_RD: n_state = spq_pkg::S_SHIFT_WR;
            spq_pkg::S_SHIFT_WR: begin
                n_state = (r_idx == r_pos) ? spq_pkg::S_PLACE : spq_pkg::S_SHIFT_RD;
            end
            spq_pkg::S_PLACE:    n_state = spq_pkg::S_DONE;
            spq_pkg::S_POP_DATA: n_state = spq_pkg::S_DONE;
            spq_pkg::S_DONE:     n_state = i_out_free ? spq_pkg::S_IDLE : spq_pkg::S_DONE;
            default:             n_state = spq_pkg::S_IDLE;
        endcase
    end

    // Datapath updates and memory controls.
    always_comb begin
        n_head    = r_head;
        n_count   = r_count;
        n_pos     = r_pos;
        n_idx     = r_idx;
        n_status  = r_status;
        n_popped  = r_popped;
        ram_we    = 1'b0;
        ram_wdata = ram_rdata;
        unique case (r_state)
            spq_pkg::S_IDLE: begin
                if (accept) begin
                    n_status = spq_pkg::ST_OK;
                    n_popped = '0;
                    n_pos    = '0;
                    case (i_req.operation)
                        spq_pkg::OP_PUSH: begin
                            if (is_full) begin
                                n_status = spq_pkg::ST_FULL;
                            end else begin
                                n_head = (r_head == '0) ? LAST : r_head - AW'(1);
                            end
                        end
                        spq_pkg::OP_SORTED: begin
                            if (is_full) begin
                                n_status = spq_pkg::ST_FULL;
                            end
                        end
                        spq_pkg::OP_POP: begin
                            if (is_empty) begin
                                n_status = spq_pkg::ST_EMPTY;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            spq_pkg::S_SCAN_CMP: begin
                if (key_lower) begin
                    n_idx = AW'(r_count - CW'(1));
                end else if (!scan_last) begin
                    n_pos = r_pos + AW'(1);
                end else begin
                    n_pos = AW'(r_count);
                end
            end
            spq_pkg::S_SHIFT_WR: begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
                n_idx     = r_idx - AW'(1);
            end
            spq_pkg::S_PLACE: begin
                ram_we    = 1'b1;
                ram_wdata = r_item;
                n_count   = r_count + CW'(1);
            end
            spq_pkg::S_POP_DATA: begin
                n_popped = ram_rdata;
                n_head   = (r_head == LAST) ? '0 : r_head + AW'(1);
                n_count  = r_count - CW'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= spq_pkg::S_IDLE;
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos    <= n_pos;
        r_idx    <= n_idx;
        r_status <= n_status;
        r_popped <= n_popped;
        if (accept) begin
            r_op                <= i_req.operation;
            r_by                <= i_req.order_by;
            r_item.id           <= i_req.item_id;
            r_item.runtime      <= i_req.item_runtime;
            r_item.coverage     <= i_req.item_coverage;
        end
    end

    assign i_req.ready = (r_state == spq_pkg::S_IDLE);

    assign occ_ext = {7'd0, r_count};

    assign o_res_valid           = (r_state == spq_pkg::S_DONE) && i_out_free;
    assign o_res.status          = r_status;
    assign o_res.popped_id       = (r_op == spq_pkg::OP_POP) ? r_popped.id : '0;
    assign o_res.popped_runtime  = r_popped.runtime;
    assign o_res.popped_coverage = r_popped.coverage;
    assign o_res.occupancy       = occ_ext[6:0];
    assign o_count               = r_count;

endmodule

/* rtl/sorted_priority_queue_unit.sv */
// ----------------------------------------------------------------------------
// Sorted priority queue unit
// Bounded queue of work items with push-to-front, stable descending sorted
// insert by runtime or coverage key, and pop-from-front.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Word carried
//  ---------+-----------+-------------------------------------------------------
//  i_req    | in        | operation, order_by, item_id, item_runtime,
//           |           | item_coverage
//  o_rsp    | out       | status, popped_id, popped_runtime, popped_coverage,
//           |           | occupancy
//
// A push or a pop moves the front pointer of a circular RAM buffer; a full, empty
// or no-op word changes no entry. A sorted insert scans from the front for the
// first lower key and shifts the later entries back, as the registered RAM read
// splits each compare or move into a read state and a compare or write state.
// Reset clears the sequencer state, front pointer, count and output valid flag.
// Ready is low while a word is in flight or its result waits to be registered.
//
module sorted_priority_queue_unit #(
    parameter int CAPACITY = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    spq_in_if.sink    i_req,
    spq_out_if.source o_rsp
);

`include "sorted_priority_queue_unit_macros.svh"

    localparam int CW = $clog2(CAPACITY + 1);

    logic             r_out_valid, n_out_valid;
    spq_pkg::t_result r_out, n_out;
    logic             out_free;
    logic             res_valid;
    spq_pkg::t_result res;
    logic [CW-1:0]    count;
    logic             rsp_failed;
    logic [spq_pkg::ENTRY_W-1:0] rsp_popped;

    // The output register is free when empty or being drained this cycle.
    assign out_free = !r_out_valid || o_rsp.ready;

    spq_seq #(
        .CAPACITY (CAPACITY)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_out_free  (out_free),
        .o_res_valid (res_valid),
        .o_res       (res),
        .o_count     (count)
    );

    // Output register: loaded with a finished result, held while stalled.
    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (res_valid) begin
            n_out_valid = 1'b1;
            n_out       = res;
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.status          = r_out.status;
    assign o_rsp.popped_id       = r_out.popped_id;
    assign o_rsp.popped_runtime  = r_out.popped_runtime;
    assign o_rsp.popped_coverage = r_out.popped_coverage;
    assign o_rsp.occupancy       = r_out.occupancy;

    assign rsp_failed = o_rsp.valid && (o_rsp.status != spq_pkg::ST_OK);
    assign rsp_popped = {o_rsp.popped_id, o_rsp.popped_runtime, o_rsp.popped_coverage};

    // The entry count can never pass the capacity.
    `SPQ_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, count <= CW'(CAPACITY))
    // Every accepted word leaves the sequencer busy, with ready low, in the following cycle.
    `SPQ_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_req.valid && i_req.ready, !i_req.ready)
    // A failed operation never reports a removed entry.
    `SPQ_ASSERT_IMP(a_fail_no_data, i_clk, i_rst_n, rsp_failed, rsp_popped == '0)

endmodule
